>>> src/prq_pkg.sv
`timescale 1ns / 1ps

package prq_pkg;

    // operation codes
    localparam logic [2:0] OP_ENQUEUE  = 3'd0;
    localparam logic [2:0] OP_DISPATCH = 3'd1;
    localparam logic [2:0] OP_TICK     = 3'd2;
    localparam logic [2:0] OP_YIELD    = 3'd3;
    localparam logic [2:0] OP_RELEASE  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NONE     = 3'd1;
    localparam logic [2:0] ST_BAD_PRI  = 3'd2;
    localparam logic [2:0] ST_QUEUED   = 3'd3;
    localparam logic [2:0] ST_NO_YIELD = 3'd4;

    // input request
    typedef struct packed {
        logic [2:0] operation;
        logic [5:0] thread_id;
        logic [3:0] priority_req;
    } t_req;

    // result
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] chosen_id;
        logic [2:0] chosen_priority;
        logic       switched;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic link_read;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic need_link;
    } t_sts;

endpackage

>>> src/prq_ram.sv
`timescale 1ns / 1ps

module prq_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> src/prq_ctrl.sv
`timescale 1ns / 1ps

module prq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  prq_pkg::t_sts i_sts,
    output prq_pkg::t_cmd o_cmd
);
    import prq_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LINK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    // commands from state
    always_comb begin
        o_cmd           = '0;
        o_cmd.clr_step  = (r_state == S_CLEAR);
        o_cmd.accept    = (r_state == S_IDLE) && i_valid;
        o_cmd.link_read = (r_state == S_EXEC) && i_sts.need_link;
        o_cmd.commit    = ((r_state == S_EXEC) && !i_sts.need_link && out_free)
                       || ((r_state == S_LINK) && out_free);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.need_link) begin
                    n_state = S_LINK;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_LINK: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // result slot
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> src/prq_dpath.sv
`timescale 1ns / 1ps

module prq_dpath #(
    parameter int LEVELS  = 8,
    parameter int THREADS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  prq_pkg::t_req i_req,
    input  prq_pkg::t_cmd i_cmd,
    output prq_pkg::t_sts o_sts,
    output prq_pkg::t_rsp o_rsp
);
    import prq_pkg::*;

    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);
    localparam logic [TW-1:0] LAST_TID = TW'(THREADS - 1);

    // latched request
    logic [2:0]    r_op;
    logic [5:0]    r_tid;
    logic [3:0]    r_pri;
    logic [LW-1:0] r_lvl;
    logic          r_any;
    logic          r_use_link;

    // scheduler state
    logic [LEVELS-1:0] r_nonempty;
    logic [LEVELS-1:0] n_nonempty;
    logic [TW-1:0]     r_run_id;
    logic [LW-1:0]     r_run_lvl;
    logic              r_run_valid;
    logic              r_yield;
    logic [TW-1:0]     r_clr_cnt;
    t_rsp              r_rsp;
    t_rsp              n_rsp;

    // memory ports
    logic [TW-1:0] link_rd;
    logic [TW-1:0] head_rd;
    logic [TW-1:0] tail_rd;
    logic          queued_rd;
    logic          link_we;
    logic          head_we;
    logic          tail_we;
    logic          queued_we;
    logic [LW-1:0] head_waddr;
    logic [TW-1:0] head_wdata;
    logic [TW-1:0] queued_waddr;
    logic [LW-1:0] lvl_raddr;

    // decode
    logic [LW-1:0] enc;
    logic [TW-1:0] tid_w;
    logic [LW-1:0] lvl_e;
    logic [TW-1:0] app_tid;
    logic [LW-1:0] app_lvl;
    logic          bad;
    logic          dup;
    logic          app_ok;
    logic          disp_ok;
    logic          yield_ok;

    // most urgent non-empty level
    always_comb begin
        enc = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                enc = LW'(i);
            end
        end
    end

    // level read address at accept
    always_comb begin
        case (i_req.operation)
            OP_YIELD:    lvl_raddr = r_run_lvl;
            OP_DISPATCH: lvl_raddr = enc;
            default:     lvl_raddr = LW'(i_req.priority_req);
        endcase
    end

    // request decode in the execute step
    assign tid_w    = TW'(r_tid);
    assign lvl_e    = LW'(r_pri);
    assign bad      = (32'(r_tid) >= THREADS) || (32'(r_pri) >= LEVELS);
    assign dup      = queued_rd || (r_run_valid && (r_run_id == tid_w));
    assign yield_ok = (r_op == OP_YIELD) && r_run_valid && r_yield;
    assign app_ok   = ((r_op == OP_ENQUEUE) && !bad && !dup) || yield_ok;
    assign disp_ok  = (r_op == OP_DISPATCH) && !r_run_valid && r_any;
    assign app_tid  = (r_op == OP_YIELD) ? r_run_id : tid_w;
    assign app_lvl  = (r_op == OP_YIELD) ? r_run_lvl : lvl_e;

    assign o_sts.need_link = disp_ok && !r_use_link && (head_rd != tail_rd);
    assign o_sts.clr_done  = (r_clr_cnt == LAST_TID);

    // memory write controls
    assign link_we    = i_cmd.commit && app_ok && r_nonempty[app_lvl];
    assign tail_we    = i_cmd.commit && app_ok;
    assign head_we    = i_cmd.commit && ((app_ok && !r_nonempty[app_lvl])
                                       || (disp_ok && r_use_link));
    assign head_waddr = app_ok ? app_lvl : r_lvl;
    assign head_wdata = app_ok ? app_tid : link_rd;
    assign queued_we  = i_cmd.clr_step || (i_cmd.commit && (app_ok || disp_ok));
    assign queued_waddr = i_cmd.clr_step ? r_clr_cnt : (app_ok ? app_tid : head_rd);

    prq_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (tail_rd),
        .i_wdata (app_tid),
        .i_re    (i_cmd.link_read),
        .i_raddr (head_rd),
        .o_rdata (link_rd)
    );

    prq_ram #(.WIDTH(1), .DEPTH(THREADS)) u_queued (
        .i_clk   (i_clk),
        .i_we    (queued_we),
        .i_waddr (queued_waddr),
        .i_wdata (app_ok && !i_cmd.clr_step),
        .i_re    (i_cmd.accept),
        .i_raddr (TW'(i_req.thread_id)),
        .o_rdata (queued_rd)
    );

    prq_ram #(.WIDTH(TW), .DEPTH(LEVELS)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (lvl_raddr),
        .o_rdata (head_rd)
    );

    prq_ram #(.WIDTH(TW), .DEPTH(LEVELS)) u_tail (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (app_lvl),
        .i_wdata (app_tid),
        .i_re    (i_cmd.accept),
        .i_raddr (lvl_raddr),
        .o_rdata (tail_rd)
    );

    // level occupancy update
    always_comb begin
        n_nonempty = r_nonempty;
        for (int i = 0; i < LEVELS; i++) begin
            if (app_ok && (app_lvl == LW'(i))) begin
                n_nonempty[i] = 1'b1;
            end
            if (disp_ok && !r_use_link && (r_lvl == LW'(i))) begin
                n_nonempty[i] = 1'b0;
            end
        end
    end

    // result of the current request
    always_comb begin
        n_rsp = '0;
        case (r_op)
            OP_ENQUEUE: begin
                if (bad) begin
                    n_rsp.status = ST_BAD_PRI;
                end else if (dup) begin
                    n_rsp.status = ST_QUEUED;
                end
            end
            OP_DISPATCH: begin
                if (r_run_valid) begin
                    n_rsp.chosen_id       = 6'(r_run_id);
                    n_rsp.chosen_priority = 3'(r_run_lvl);
                end else if (!r_any) begin
                    n_rsp.status = ST_NONE;
                end else begin
                    n_rsp.chosen_id       = 6'(head_rd);
                    n_rsp.chosen_priority = 3'(r_lvl);
                    n_rsp.switched        = 1'b1;
                end
            end
            OP_YIELD: begin
                if (yield_ok) begin
                    n_rsp.chosen_id       = 6'(r_run_id);
                    n_rsp.chosen_priority = 3'(r_run_lvl);
                    n_rsp.switched        = 1'b1;
                end else begin
                    n_rsp.status = ST_NO_YIELD;
                end
            end
            OP_RELEASE: begin
                if (!r_run_valid) begin
                    n_rsp.status = ST_NONE;
                end
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty  <= '0;
            r_run_id    <= '0;
            r_run_lvl   <= '0;
            r_run_valid <= 1'b0;
            r_yield     <= 1'b0;
            r_clr_cnt   <= '0;
            r_use_link  <= 1'b0;
        end else begin
            if (i_cmd.clr_step && !o_sts.clr_done) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.accept) begin
                r_use_link <= 1'b0;
            end else if (i_cmd.link_read) begin
                r_use_link <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_nonempty <= n_nonempty;
                if (disp_ok) begin
                    r_run_id    <= head_rd;
                    r_run_lvl   <= r_lvl;
                    r_run_valid <= 1'b1;
                    r_yield     <= 1'b0;
                end else if (yield_ok || (r_op == OP_RELEASE)) begin
                    r_run_valid <= 1'b0;
                    r_yield     <= 1'b0;
                end else if ((r_op == OP_TICK) && r_run_valid) begin
                    r_yield <= 1'b1;
                end
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_req.operation;
            r_tid <= i_req.thread_id;
            r_pri <= i_req.priority_req;
            r_lvl <= enc;
            r_any <= |r_nonempty;
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

>>> src/priority_ready_queue_scheduler_core.sv
`timescale 1ns / 1ps
// one request at a time: result registered in the execute step, or in the link step for a
// dispatch that must follow the level's link (registered read of the link memory)
// a new request is accepted only once the result of the last one is registered
// a held result stalls the final step until the result register is free
// reset (synchronous, active low): a clearing pass over every entry of the
// queued-flag memory runs first, with o_ready low

module priority_ready_queue_scheduler_core #(
    parameter int LEVELS  = 8,
    parameter int THREADS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  prq_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output prq_pkg::t_rsp o_rsp
);
    import prq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    prq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // queues, running slot and result register
    prq_dpath #(.LEVELS(LEVELS), .THREADS(THREADS)) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

>>> src/prq_checker.sv
`timescale 1ns / 1ps

module prq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input prq_pkg::t_req i_req,
    input logic          o_valid,
    input logic          i_ready,
    input prq_pkg::t_rsp o_rsp
);
    import prq_pkg::*;

    // a held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // one request in flight: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while busy");

    // a switch is always a successful result
    a_switch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.switched |-> o_rsp.status == ST_OK)
        else $error("switch with error status");

    // error results carry no thread
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status != ST_OK) |->
            (o_rsp.chosen_id == 6'd0) && (o_rsp.chosen_priority == 3'd0) && !o_rsp.switched)
        else $error("error result carries a thread");

endmodule

bind priority_ready_queue_scheduler_core prq_checker u_prq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_req   (i_req),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);
